FILE: design/enum_range_label_table_top_macros.svh
// Assertion helpers shared by the checker files of this block.
// Every macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef ENUM_RANGE_LABEL_TABLE_TOP_MACROS_SVH
`define ENUM_RANGE_LABEL_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERT_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ert port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ERT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ert port check failed");

`endif

FILE: design/ert_pkg.sv
`default_nettype none

package ert_pkg;

	localparam int ENTRIES     = 32;
	localparam int LABEL_BITS  = 16;
	localparam int MAX_RESULTS = 32;

	localparam int VAL_W  = 64;
	localparam int TAG_W  = 16;
	localparam int LCNT_W = 6;
	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);
	// Labels are masked to LABEL_BITS and then to the 16-bit tag port.
	localparam int LBL_W  = (LABEL_BITS < TAG_W) ? LABEL_BITS : TAG_W;

	typedef logic [1:0] req_t;
	localparam req_t REQ_INS = 2'd0;
	localparam req_t REQ_VAL = 2'd1;
	localparam req_t REQ_LBL = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] low;
		logic [VAL_W-1:0] high;
		logic [LBL_W-1:0] label;
		logic             single;
	} entry_t;

	typedef struct packed {
		logic a_le_b;
		logic b_le_c;
		logic a_eq_b;
		logic lbl_eq;
	} cmp_t;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INS_SCAN = 6'b000010,
		S_INS_WR   = 6'b000100,
		S_FWD      = 6'b001000,
		S_REV      = 6'b010000,
		S_LBL      = 6'b100000
	} state_t;

endpackage

`default_nettype wire

FILE: design/ert_mem.sv
`default_nettype none

module ert_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [ert_pkg::IDX_W-1:0] waddr,
	input  wire ert_pkg::entry_t           wdata,
	input  wire logic [ert_pkg::IDX_W-1:0] raddr,
	output ert_pkg::entry_t                rdata
);

	ert_pkg::entry_t mem_q [ert_pkg::ENTRIES];
	ert_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/ert_match.sv
`default_nettype none

module ert_match (
	input  wire logic                      mode,
	input  wire logic [ert_pkg::VAL_W-1:0] op_a,
	input  wire logic [ert_pkg::VAL_W-1:0] op_b,
	input  wire logic [ert_pkg::VAL_W-1:0] op_c,
	input  wire logic [ert_pkg::LBL_W-1:0] lbl_x,
	input  wire logic [ert_pkg::LBL_W-1:0] lbl_y,
	output ert_pkg::cmp_t                  cmp
);

	logic [ert_pkg::VAL_W-1:0] a_b;
	logic [ert_pkg::VAL_W-1:0] b_b;
	logic [ert_pkg::VAL_W-1:0] c_b;

	// Flipping the sign bit turns a two's complement order into an unsigned one.
	always_comb begin
		a_b = {op_a[ert_pkg::VAL_W-1] ^ mode, op_a[ert_pkg::VAL_W-2:0]};
		b_b = {op_b[ert_pkg::VAL_W-1] ^ mode, op_b[ert_pkg::VAL_W-2:0]};
		c_b = {op_c[ert_pkg::VAL_W-1] ^ mode, op_c[ert_pkg::VAL_W-2:0]};
		cmp.a_le_b = (a_b <= b_b);
		cmp.b_le_c = (b_b <= c_b);
		cmp.a_eq_b = (op_a == op_b);
		cmp.lbl_eq = (lbl_x == lbl_y);
	end

endmodule

`default_nettype wire

FILE: design/enum_range_label_table_top.sv
// Channel  Dir  Handshake             Fields of one beat
// request  in   start, busy           req_type, range_first, range_second, probe_value, tag
// result   out  result_valid          hit, hit_label, hit_low/high, table_full, label_count, last
// config   in   cfg_valid, cfg_ready  cfg_data (signed_mode)
//
// While busy, an insert or a label lookup makes one pass over the stored entries and a value
// lookup makes two; the single memory read port reads each stored entry once per pass.
// A full-table insert and an unknown request never raise busy.
// Matches leave at most one per cycle, the last beat in the first cycle with busy low, and
// the receiver cannot stall any of them. Reset empties the table; the memory is not cleared.
`default_nettype none

module enum_range_label_table_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  req_type,
	input  wire logic [63:0]                 range_first,
	input  wire logic [63:0]                 range_second,
	input  wire logic [63:0]                 probe_value,
	input  wire logic [15:0]                 tag,
	output logic                             result_valid,
	output logic                             hit,
	output logic [15:0]                      hit_label,
	output logic [63:0]                      hit_low,
	output logic [63:0]                      hit_high,
	output logic                             table_full,
	output logic [5:0]                       label_count,
	output logic                             last,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_data
);

	ert_pkg::state_t                state_q;
	logic                           mode_q;
	logic [ert_pkg::CNT_W-1:0]      cnt_q;
	logic [ert_pkg::LCNT_W-1:0]     dist_q;
	logic [ert_pkg::CNT_W-1:0]      remain_q;
	logic [ert_pkg::IDX_W-1:0]      ptr_q;
	logic                           rd_vld_s1;
	logic [ert_pkg::NRES_W-1:0]     nres_q;
	logic                           seen_q;
	logic                           pend_vld_q;
	logic                           res_valid_q;

	logic [ert_pkg::VAL_W-1:0]      probe_q;
	logic [ert_pkg::LBL_W-1:0]      tag_q;
	logic [ert_pkg::VAL_W-1:0]      ins_low_q;
	logic [ert_pkg::VAL_W-1:0]      ins_high_q;
	ert_pkg::entry_t                pend_q;
	logic                           out_hit_q;
	logic [ert_pkg::LBL_W-1:0]      out_label_q;
	logic [ert_pkg::VAL_W-1:0]      out_low_q;
	logic [ert_pkg::VAL_W-1:0]      out_high_q;
	logic                           out_full_q;
	logic                           out_last_q;

	ert_pkg::entry_t                rd_e;
	ert_pkg::entry_t                wr_e;
	ert_pkg::cmp_t                  cmp;
	logic                           idle;
	logic                           accept;
	logic                           acc_ins;
	logic                           tbl_full;
	logic                           emit_full;
	logic                           emit_ins;
	logic                           phase_done;
	logic                           scan_end;
	logic                           hit_now;
	logic                           take;
	logic                           emit_mid;
	logic                           swap;
	logic [ert_pkg::LBL_W-1:0]      tag_in;
	logic [ert_pkg::CNT_W-1:0]      cnt_dec;
	logic [ert_pkg::VAL_W-1:0]      mux_a;
	logic [ert_pkg::VAL_W-1:0]      mux_b;

	assign tag_in   = tag[ert_pkg::LBL_W-1:0];
	assign idle     = (state_q == ert_pkg::S_IDLE);
	assign accept   = idle && start;
	assign acc_ins  = accept && (req_type == ert_pkg::REQ_INS);
	assign tbl_full = (cnt_q == ert_pkg::CNT_W'(ert_pkg::ENTRIES));
	assign emit_full = acc_ins && tbl_full;
	assign emit_ins  = (state_q == ert_pkg::S_INS_WR);
	assign phase_done = (remain_q == '0) && !rd_vld_s1;
	assign scan_end  = phase_done && ((state_q == ert_pkg::S_REV) ||
		(state_q == ert_pkg::S_LBL));
	assign cnt_dec   = cnt_q - ert_pkg::CNT_W'(1);

	// While idle the compare unit orders the bounds of an arriving insert;
	// otherwise it compares the entry just read against the held request.
	assign mux_a = idle ? range_first  : rd_e.low;
	assign mux_b = idle ? range_second : probe_q;
	assign swap  = !cmp.a_le_b;

	ert_match u_match (
		.mode  (mode_q),
		.op_a  (mux_a),
		.op_b  (mux_b),
		.op_c  (rd_e.high),
		.lbl_x (rd_e.label),
		.lbl_y (tag_q),
		.cmp   (cmp)
	);

	always_comb begin
		wr_e.low    = ins_low_q;
		wr_e.high   = ins_high_q;
		wr_e.label  = tag_q;
		wr_e.single = (ins_low_q == ins_high_q);
	end

	ert_mem u_mem (
		.clk   (clk),
		.we    (emit_ins),
		.waddr (cnt_q[ert_pkg::IDX_W-1:0]),
		.wdata (wr_e),
		.raddr (ptr_q),
		.rdata (rd_e)
	);

	always_comb begin
		case (state_q)
			ert_pkg::S_FWD: hit_now = rd_e.single && cmp.a_eq_b;
			ert_pkg::S_REV: hit_now = !rd_e.single && cmp.a_le_b && cmp.b_le_c;
			ert_pkg::S_LBL: hit_now = cmp.lbl_eq;
			default:        hit_now = 1'b0;
		endcase
	end

	assign take     = rd_vld_s1 && hit_now &&
		(nres_q < ert_pkg::NRES_W'(ert_pkg::MAX_RESULTS));
	// A match is held back one beat so that the final result can carry last.
	assign emit_mid = take && pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ert_pkg::S_IDLE;
			mode_q      <= 1'b0;
			cnt_q       <= '0;
			dist_q      <= '0;
			remain_q    <= '0;
			rd_vld_s1   <= 1'b0;
			nres_q      <= '0;
			seen_q      <= 1'b0;
			pend_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit_full || emit_ins || scan_end || emit_mid;
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			rd_vld_s1 <= (remain_q != '0);
			if (remain_q != '0) begin
				remain_q <= remain_q - ert_pkg::CNT_W'(1);
			end
			if (take) begin
				nres_q     <= nres_q + ert_pkg::NRES_W'(1);
				pend_vld_q <= 1'b1;
			end
			if ((state_q == ert_pkg::S_INS_SCAN) && rd_vld_s1 && cmp.lbl_eq) begin
				seen_q <= 1'b1;
			end
			case (state_q)
				ert_pkg::S_IDLE: begin
					if (start) begin
						nres_q     <= '0;
						pend_vld_q <= 1'b0;
						seen_q     <= 1'b0;
						case (req_type)
							ert_pkg::REQ_INS: begin
								if (!tbl_full) begin
									remain_q <= cnt_q;
									state_q  <= ert_pkg::S_INS_SCAN;
								end
							end
							ert_pkg::REQ_VAL: begin
								remain_q <= cnt_q;
								state_q  <= ert_pkg::S_FWD;
							end
							ert_pkg::REQ_LBL: begin
								remain_q <= cnt_q;
								state_q  <= ert_pkg::S_LBL;
							end
							default: ;
						endcase
					end
				end
				ert_pkg::S_INS_SCAN: begin
					if (phase_done) begin
						state_q <= ert_pkg::S_INS_WR;
					end
				end
				ert_pkg::S_INS_WR: begin
					cnt_q <= cnt_q + ert_pkg::CNT_W'(1);
					if (!seen_q) begin
						dist_q <= dist_q + ert_pkg::LCNT_W'(1);
					end
					state_q <= ert_pkg::S_IDLE;
				end
				ert_pkg::S_FWD: begin
					if (phase_done) begin
						remain_q <= cnt_q;
						state_q  <= ert_pkg::S_REV;
					end
				end
				ert_pkg::S_REV, ert_pkg::S_LBL: begin
					if (phase_done) begin
						state_q <= ert_pkg::S_IDLE;
					end
				end
				default: state_q <= ert_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (remain_q != '0) begin
			if (state_q == ert_pkg::S_REV) begin
				ptr_q <= ptr_q - ert_pkg::IDX_W'(1);
			end else begin
				ptr_q <= ptr_q + ert_pkg::IDX_W'(1);
			end
		end
		if (accept) begin
			ptr_q      <= '0;
			probe_q    <= probe_value;
			tag_q      <= tag_in;
			ins_low_q  <= swap ? range_second : range_first;
			ins_high_q <= swap ? range_first : range_second;
		end
		if ((state_q == ert_pkg::S_FWD) && phase_done) begin
			ptr_q <= cnt_dec[ert_pkg::IDX_W-1:0];
		end
		if (take) begin
			pend_q <= rd_e;
		end

		if (emit_full) begin
			out_hit_q   <= 1'b0;
			out_label_q <= '0;
			out_low_q   <= '0;
			out_high_q  <= '0;
			out_full_q  <= 1'b1;
			out_last_q  <= 1'b1;
		end else if (emit_ins) begin
			out_hit_q   <= 1'b0;
			out_label_q <= tag_q;
			out_low_q   <= ins_low_q;
			out_high_q  <= ins_high_q;
			out_full_q  <= 1'b0;
			out_last_q  <= 1'b1;
		end else if (emit_mid) begin
			out_hit_q   <= 1'b1;
			out_label_q <= pend_q.label;
			out_low_q   <= pend_q.low;
			out_high_q  <= pend_q.high;
			out_full_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (scan_end) begin
			out_hit_q   <= pend_vld_q;
			out_label_q <= pend_vld_q ? pend_q.label : '0;
			out_low_q   <= pend_vld_q ? pend_q.low : '0;
			out_high_q  <= pend_vld_q ? pend_q.high : '0;
			out_full_q  <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign busy         = !idle;
	// The compare mode may only change between requests.
	assign cfg_ready    = idle;
	assign result_valid = res_valid_q;
	assign hit          = out_hit_q;
	assign hit_label    = ert_pkg::TAG_W'(out_label_q);
	assign hit_low      = out_low_q;
	assign hit_high     = out_high_q;
	assign table_full   = out_full_q;
	assign label_count  = dist_q;
	assign last         = out_last_q;

endmodule

`default_nettype wire

FILE: design/ert_chk.sv
`default_nettype none
`include "enum_range_label_table_top_macros.svh"

module ert_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  req_type,
	input wire logic        result_valid,
	input wire logic        hit,
	input wire logic        table_full,
	input wire logic        last
);

	// Every beat but the final one of a request shows while busy is high.
	`ERT_ASSERT_NOW(a_last_vs_busy, result_valid, last != busy)

	// A full-table beat never carries a match and ends its request.
	`ERT_ASSERT_NOW(a_full_beat, result_valid && table_full, !hit && last)

	// An accepted insert either starts its scan or reports a full table at once.
	`ERT_ASSERT_NEXT(a_ins_start, start && !busy && req_type == ert_pkg::REQ_INS,
		busy || (result_valid && table_full))

	// An accepted lookup always occupies the block and raises busy.
	`ERT_ASSERT_NEXT(a_lkp_start, start && !busy && (req_type == ert_pkg::REQ_VAL ||
		req_type == ert_pkg::REQ_LBL), busy)

endmodule

bind enum_range_label_table_top ert_chk u_ert_chk (.*);

`default_nettype wire

FILE: tb/enum_range_label_table_top_test.sv
`default_nettype none

module enum_range_label_table_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam ert_pkg::req_t REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic        hit;
		logic [15:0] label;
		logic [63:0] low;
		logic [63:0] high;
		logic        full;
		logic [5:0]  count;
		logic        last;
	} match_beat_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	ert_pkg::req_t req_type;
	logic [63:0]   range_first;
	logic [63:0]   range_second;
	logic [63:0]   probe_value;
	logic [15:0]   tag;
	logic          result_valid;
	logic          hit;
	logic [15:0]   hit_label;
	logic [63:0]   hit_low;
	logic [63:0]   hit_high;
	logic          table_full;
	logic [5:0]    label_count;
	logic          last;
	logic          cfg_valid;
	logic          cfg_ready;
	logic          cfg_data;

	enum_range_label_table_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.range_first (range_first),
		.range_second(range_second),
		.probe_value (probe_value),
		.tag         (tag),
		.result_valid(result_valid),
		.hit         (hit),
		.hit_label   (hit_label),
		.hit_low     (hit_low),
		.hit_high    (hit_high),
		.table_full  (table_full),
		.label_count (label_count),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// Mirror of the lookup table, updated as each request is accepted.
	logic [63:0] tbl_low[ert_pkg::ENTRIES];
	logic [63:0] tbl_high[ert_pkg::ENTRIES];
	logic [15:0] tbl_label[ert_pkg::ENTRIES];
	bit          tbl_single[ert_pkg::ENTRIES];
	int          tbl_used;
	int          labels_seen;
	bit          cmp_signed;

	match_beat_t pending_matches[$];
	int          failures;
	bit          steady;
	int          n_inserts, n_rejected, n_value, n_label, n_beats, n_hits;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding.", pending_matches.size());
		$display("FAILED: results differ");
		$finish;
	end

	function automatic bit ordered_le(logic [63:0] a, logic [63:0] b);
		if (cmp_signed)
			return $signed(a) <= $signed(b);
		return a <= b;
	endfunction

	function automatic match_beat_t make_beat(logic h, logic [15:0] lbl, logic [63:0] lo,
			logic [63:0] hi, logic full);
		match_beat_t b;
		b.hit   = h;
		b.label = lbl;
		b.low   = lo;
		b.high  = hi;
		b.full  = full;
		b.count = labels_seen[5:0];
		b.last  = 1'b0;
		return b;
	endfunction

	function automatic void predict_request(ert_pkg::req_t kind, logic [63:0] first,
			logic [63:0] second, logic [63:0] probe, logic [15:0] lbl);
		match_beat_t batch[$];
		match_beat_t b;
		logic [63:0] lo, hi;
		bit          known;
		lo = first;
		hi = second;
		known = 1'b0;
		case (kind)
			ert_pkg::REQ_INS: begin
				n_inserts++;
				if (tbl_used >= ert_pkg::ENTRIES) begin
					n_rejected++;
					batch.push_back(make_beat(1'b0, '0, '0, '0, 1'b1));
				end else begin
					if (lo != hi && !ordered_le(lo, hi)) begin
						lo = second;
						hi = first;
					end
					for (int j = 0; j < tbl_used; j++)
						if (tbl_label[j] == lbl)
							known = 1'b1;
					tbl_low[tbl_used]    = lo;
					tbl_high[tbl_used]   = hi;
					tbl_label[tbl_used]  = lbl;
					tbl_single[tbl_used] = (lo == hi);
					tbl_used++;
					if (!known)
						labels_seen++;
					batch.push_back(make_beat(1'b0, lbl, lo, hi, 1'b0));
				end
			end
			ert_pkg::REQ_VAL: begin
				n_value++;
				// Exact-value entries in insertion order, then ranges newest first.
				for (int j = 0; j < tbl_used && batch.size() < ert_pkg::MAX_RESULTS; j++)
					if (tbl_single[j] && tbl_low[j] == probe)
						batch.push_back(make_beat(1'b1, tbl_label[j], tbl_low[j],
							tbl_high[j], 1'b0));
				for (int j = tbl_used - 1; j >= 0 && batch.size() < ert_pkg::MAX_RESULTS; j--)
					if (!tbl_single[j] && ordered_le(tbl_low[j], probe) &&
							ordered_le(probe, tbl_high[j]))
						batch.push_back(make_beat(1'b1, tbl_label[j], tbl_low[j],
							tbl_high[j], 1'b0));
			end
			ert_pkg::REQ_LBL: begin
				n_label++;
				for (int j = 0; j < tbl_used && batch.size() < ert_pkg::MAX_RESULTS; j++)
					if (tbl_label[j] == lbl)
						batch.push_back(make_beat(1'b1, lbl, tbl_low[j], tbl_high[j], 1'b0));
			end
			default: return;
		endcase
		if (batch.size() == 0)
			batch.push_back(make_beat(1'b0, '0, '0, '0, 1'b0));
		b = batch.pop_back();
		b.last = 1'b1;
		batch.push_back(b);
		foreach (batch[k])
			pending_matches.push_back(batch[k]);
	endfunction

	function automatic void report_mismatch(string what, match_beat_t want, match_beat_t got);
		failures++;
		if (failures <= 10) begin
			$display("%0t %s: expected hit=%0b label=%h low=%h high=%h full=%0b count=%0d last=%0b",
				$realtime, what, want.hit, want.label, want.low, want.high, want.full,
				want.count, want.last);
			$display("    got hit=%0b label=%h low=%h high=%h full=%0b count=%0d last=%0b",
				got.hit, got.label, got.low, got.high, got.full, got.count, got.last);
		end
	endfunction

	// Prediction and checking share one process so that their order at an edge is fixed.
	always @(posedge clk) begin : monitor
		match_beat_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cmp_signed = cfg_data;
			if (start && !busy)
				predict_request(req_type, range_first, range_second, probe_value, tag);
			if (result_valid) begin
				got.hit   = hit;
				got.label = hit_label;
				got.low   = hit_low;
				got.high  = hit_high;
				got.full  = table_full;
				got.count = label_count;
				got.last  = last;
				n_beats++;
				if (hit === 1'b1)
					n_hits++;
				if (pending_matches.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_matches.pop_front();
					if (got !== want)
						report_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	function automatic int idle_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4, 5: return 64'($urandom_range(0, 24));
			6, 7: return -64'($urandom_range(1, 24));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [15:0] pick_label();
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 5));
	endfunction

	task automatic send_request(ert_pkg::req_t kind, logic [63:0] first, logic [63:0] second,
			logic [63:0] probe, logic [15:0] lbl);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		req_type     <= kind;
		range_first  <= first;
		range_second <= second;
		probe_value  <= probe;
		tag          <= lbl;
		do @(posedge clk); while (busy);
	endtask

	// Holds the sender off until every predicted beat has arrived and the block is idle.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(bit mode);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_table();
		send_request(ert_pkg::REQ_VAL, '0, '0, '0, '0);
		send_request(ert_pkg::REQ_LBL, '1, '1, '1, 16'hFFFF);
		send_request(REQ_UNUSED, '1, '1, '1, 16'hFFFF);
	endtask

	task automatic test_unsigned_entries();
		send_request(ert_pkg::REQ_INS, '0, '0, '1, 16'h0000);
		send_request(ert_pkg::REQ_INS, '1, '0, '0, 16'hFFFF);
		send_request(ert_pkg::REQ_INS, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0,
			16'h0001);
		send_request(ert_pkg::REQ_INS, 64'd10, 64'd5, '0, 16'h0000);
		send_request(ert_pkg::REQ_INS, 64'd5, 64'd10, '0, 16'h0002);
		send_request(ert_pkg::REQ_VAL, '0, '0, '0, '0);
		send_request(ert_pkg::REQ_VAL, '0, '0, 64'd7, '0);
		send_request(ert_pkg::REQ_VAL, '0, '0, 64'h8000_0000_0000_0000, '0);
		send_request(ert_pkg::REQ_LBL, '0, '0, '0, 16'h0000);
	endtask

	// Bounds that swap only under one of the two modes, and entries stored under one mode
	// but searched under the other.
	task automatic test_signed_entries();
		write_mode(1'b1);
		send_request(ert_pkg::REQ_INS, -64'sd5, 64'd3, '0, 16'h0003);
		send_request(ert_pkg::REQ_INS, 64'd3, -64'sd5, '0, 16'h0003);
		send_request(ert_pkg::REQ_INS, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '0,
			16'h5A5A);
		send_request(ert_pkg::REQ_VAL, '0, '0, '1, '0);
		send_request(ert_pkg::REQ_VAL, '0, '0, '0, '0);
		send_request(ert_pkg::REQ_LBL, '0, '0, '0, 16'h0003);
		write_mode(1'b0);
		send_request(ert_pkg::REQ_VAL, '0, '0, '1, '0);
	endtask

	task automatic test_random_traffic(bit mode, int count);
		int          done, r, idx;
		logic [63:0] first, second, probe;
		logic [15:0] lbl;
		done = 0;
		write_mode(mode);
		while (done < count) begin
			if (done % 25 == 0)
				steady = ($urandom_range(0, 9) < 3);
			first  = {$urandom, $urandom};
			second = {$urandom, $urandom};
			probe  = {$urandom, $urandom};
			lbl    = 16'($urandom);
			r = $urandom_range(0, 99);
			if (r < 30) begin
				first  = pick_value();
				second = ($urandom_range(0, 9) < 3) ? first : pick_value();
				send_request(ert_pkg::REQ_INS, first, second, probe, pick_label());
				done++;
			end else if (r < 65) begin
				probe = pick_value();
				if (tbl_used > 0 && $urandom_range(0, 2) == 0) begin
					idx = $urandom_range(0, tbl_used - 1);
					probe = $urandom_range(0, 1) ? tbl_low[idx] : tbl_high[idx];
					probe = probe + 64'($urandom_range(0, 2)) - 64'd1;
				end
				send_request(ert_pkg::REQ_VAL, first, second, probe, lbl);
				done++;
			end else if (r < 95) begin
				lbl = pick_label();
				if (tbl_used > 0 && $urandom_range(0, 1) == 0)
					lbl = tbl_label[$urandom_range(0, tbl_used - 1)];
				send_request(ert_pkg::REQ_LBL, first, second, probe, lbl);
				done++;
			end else begin
				send_request(REQ_UNUSED, first, second, probe, lbl);
			end
			if ($urandom_range(0, 99) < 3)
				drain_results();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = ert_pkg::REQ_INS;
		range_first  = '0;
		range_second = '0;
		probe_value  = '0;
		tag          = '0;
		cfg_valid    = 1'b0;
		cfg_data     = 1'b0;
		tbl_used     = 0;
		labels_seen  = 0;
		cmp_signed   = 1'b0;
		failures     = 0;
		steady       = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_unsigned_entries();
		test_signed_entries();
		test_random_traffic(1'b0, 50);
		test_random_traffic(1'b1, 50);
		test_random_traffic(1'b0, 50);
		test_random_traffic(1'b1, 50);

		drain_results();
		repeat (80) @(posedge clk);
		if (pending_matches.size() != 0) begin
			failures++;
			$display("%0d expected results never arrived.", pending_matches.size());
		end
		$display("Ran %0d inserts (%0d refused on a full table), %0d value and %0d label lookups,",
			n_inserts, n_rejected, n_value, n_label);
		$display("with %0d result beats, %0d of them matches, under both compare modes.",
			n_beats, n_hits);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
